### hw/rtl/four_level_mmu_with_tlb_core_defines.svh
// Assertion macros shared by the MMU RTL.
// Used by four_level_mmu_with_tlb_core; expects clk_i and rst_ni in scope.
`ifndef FOUR_LEVEL_MMU_WITH_TLB_CORE_DEFINES_SVH
`define FOUR_LEVEL_MMU_WITH_TLB_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define MMU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define MMU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/mmu4_pkg.sv
// Shared types, codes and helpers for the four-level MMU.
// No dependencies.
`timescale 1ns / 1ps
package mmu4_pkg;
  localparam int VA_W    = 64;
  localparam int PA_W    = 52;
  localparam int FLG_W   = 12;
  localparam int PFN_W   = 40;
  localparam int TAG_W   = 52;
  localparam int ENTRY_W = 64;
  localparam int IDX_W   = 9;
  localparam int IN_W    = 128;
  localparam int OUT_W   = 160;

  localparam logic       OP_TRANSLATE = 1'b0;
  localparam logic       OP_MAP       = 1'b1;
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FAULT = 2'd1;
  localparam logic [1:0] STATUS_NOTBL = 2'd2;
  localparam logic [FLG_W-1:0] PRESENT_FLAG = 12'h001;

  typedef struct packed {
    logic lookup;
    logic fill;
    logic inval;
  } tlb_op_t;

  function automatic logic [IDX_W-1:0] level_idx(input logic [VA_W-1:0] va,
                                                 input logic [1:0] lvl);
    logic [IDX_W-1:0] r;
    case (lvl)
      2'd0: r = va[47:39];
      2'd1: r = va[38:30];
      2'd2: r = va[29:21];
      default: r = va[20:12];
    endcase
    return r;
  endfunction
endpackage

### hw/rtl/mmu4_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module mmu4_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

### hw/rtl/mmu4_tlb.sv
// Fully associative TLB: tag/frame RAM, valid bits, fill count, tag compare.
// Depends on mmu4_pkg and mmu4_ram.
`timescale 1ns / 1ps
module mmu4_tlb import mmu4_pkg::*; #(
  parameter int ENTRIES = 64,
  parameter int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  parameter int CW      = $clog2(ENTRIES + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tlb_op_t          op_i,
  input  logic [IW-1:0]    idx_i,
  input  logic [TAG_W-1:0] tag_i,
  input  logic [PFN_W-1:0] frame_i,
  output logic             match_o,
  output logic [PFN_W-1:0] frame_o,
  output logic [CW-1:0]    fill_o
);
  localparam int RW = TAG_W + PFN_W;

  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [CW-1:0]      fill_q, fill_d;
  logic               vld_rd_q;
  logic [IW-1:0]      slot;
  logic [RW-1:0]      rdata;

  always_comb begin
    slot    = (fill_q < CW'(ENTRIES)) ? fill_q[IW-1:0] : '0;
    valid_d = valid_q;
    fill_d  = fill_q;
    if (op_i.fill) begin
      valid_d[slot] = 1'b1;
      if (fill_q < CW'(ENTRIES)) begin
        fill_d = fill_q + CW'(1);
      end
    end
    if (op_i.inval) begin
      valid_d[idx_i] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      fill_q   <= '0;
      vld_rd_q <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      fill_q   <= fill_d;
      vld_rd_q <= valid_q[idx_i];
    end
  end

  mmu4_ram #(.WIDTH(RW), .DEPTH(ENTRIES), .AW(IW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (op_i.fill),
    .waddr_i (slot),
    .wdata_i ({frame_i, tag_i}),
    .raddr_i (idx_i),
    .rdata_o (rdata)
  );

  // Shared tag comparator, one slot per lookup.
  assign match_o = vld_rd_q && (rdata[TAG_W-1:0] == tag_i);
  assign frame_o = rdata[RW-1:TAG_W];
  assign fill_o  = fill_q;
endmodule

### hw/rtl/four_level_mmu_with_tlb_core.sv
// Four-level page table walker with TLB. A translate searches the filled TLB slots in order
// and walks the tables on a miss; a map walks and allocates, then searches the TLB to drop
// a stale entry. One item at a time: input is accepted only in the idle state.
// Reset: asynchronous active low; afterwards a clearing pass zeroes all PT_POOL_SIZE*512
// table RAM entries while no item is accepted. TLB valid bits and counters clear at once.
// Depends on mmu4_pkg, mmu4_tlb, mmu4_ram and the defines header.
`timescale 1ns / 1ps
`include "four_level_mmu_with_tlb_core_defines.svh"
module four_level_mmu_with_tlb_core import mmu4_pkg::*; #(
  parameter int PT_POOL_SIZE = 32,
  parameter int TLB_ENTRIES  = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // [63:0] vaddr, [115:64] frame_addr, [127:116] flags
  input  logic [IN_W-1:0]   s_axis_tdata,
  // [0] operation
  input  logic              s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // [1:0] status, [53:2] paddr, [54] tlb_hit, [86:55] hit_total,
  // [118:87] miss_total, [150:119] fault_total, [156:151] tables_in_use, [159:157] zero
  output logic [OUT_W-1:0]  m_axis_tdata
);
  localparam int TW  = $clog2(PT_POOL_SIZE);
  localparam int AW  = $clog2(PT_POOL_SIZE + 1);
  localparam int MAW = TW + IDX_W;
  localparam int MD  = PT_POOL_SIZE * 512;
  localparam int IW  = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int CW  = $clog2(TLB_ENTRIES + 1);

  localparam logic [3:0] ST_CLEAR   = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_TLB_RD  = 4'd2;
  localparam logic [3:0] ST_TLB_CMP = 4'd3;
  localparam logic [3:0] ST_WALK_RD = 4'd4;
  localparam logic [3:0] ST_WALK_EV = 4'd5;
  localparam logic [3:0] ST_CHECK   = 4'd6;
  localparam logic [3:0] ST_ALLOC   = 4'd7;
  localparam logic [3:0] ST_LEAF    = 4'd8;
  localparam logic [3:0] ST_FILL    = 4'd9;
  localparam logic [3:0] ST_DONE    = 4'd10;

  logic [3:0]       state_q, state_d;
  logic [MAW-1:0]   clr_q, clr_d;
  logic             op_q, op_d;
  logic [VA_W-1:0]  va_q, va_d;
  logic [PFN_W-1:0] frame_q, frame_d;
  logic [FLG_W-1:0] flg_q, flg_d;
  logic [1:0]       lvl_q, lvl_d;
  logic [TW-1:0]    tbl_q, tbl_d;
  logic [AW-1:0]    alloc_q, alloc_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic [PFN_W-1:0] pf_q, pf_d;
  logic [1:0]       res_status_q, res_status_d;
  logic [PA_W-1:0]  res_phys_q, res_phys_d;
  logic             res_hit_q, res_hit_d;
  logic [31:0]      hit_cnt_q, hit_cnt_d, miss_cnt_q, miss_cnt_d, fault_cnt_q, fault_cnt_d;
  logic             mvalid_q, mvalid_d;
  logic [OUT_W-1:0] mdata_q, mdata_d;

  logic               mem_we;
  logic [MAW-1:0]     mem_waddr, mem_raddr;
  logic [ENTRY_W-1:0] mem_wdata, mem_rdata;
  tlb_op_t            tlb_op;
  logic               tlb_match;
  logic [PFN_W-1:0]   tlb_frame;
  logic [CW-1:0]      tlb_fill;

  logic [PFN_W-1:0] ent_k, ent_km1, new_k;
  logic             ent_present, ent_kvalid;
  logic [AW:0]      need_sum;
  logic [AW+5:0]    alloc_ext;

  assign ent_k       = mem_rdata[51:12];
  assign ent_km1     = ent_k - PFN_W'(1);
  assign ent_present = mem_rdata[0];
  assign ent_kvalid  = (ent_k != '0) && (ent_k <= PFN_W'(alloc_q));
  assign new_k       = PFN_W'(alloc_q) + PFN_W'(1);
  assign need_sum    = {1'b0, alloc_q} + (AW+1)'(2'd3 - lvl_q);
  assign alloc_ext   = {6'b0, alloc_q};

  always_comb begin
    state_d = state_q;  clr_d = clr_q;  op_d = op_q;  va_d = va_q;
    frame_d = frame_q;  flg_d = flg_q;  lvl_d = lvl_q; tbl_d = tbl_q;
    alloc_d = alloc_q;  idx_d = idx_q;  pf_d = pf_q;
    res_status_d = res_status_q; res_phys_d = res_phys_q; res_hit_d = res_hit_q;
    hit_cnt_d = hit_cnt_q; miss_cnt_d = miss_cnt_q; fault_cnt_d = fault_cnt_q;
    mvalid_d  = mvalid_q && !m_axis_tready;
    mdata_d   = mdata_q;
    mem_we    = 1'b0;
    mem_waddr = {tbl_q, level_idx(va_q, lvl_q)};
    mem_wdata = '0;
    mem_raddr = {tbl_q, level_idx(va_q, lvl_q)};
    tlb_op    = '0;

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + MAW'(1);
        if (clr_q == MAW'(MD - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          op_d    = s_axis_tuser;
          va_d    = s_axis_tdata[63:0];
          frame_d = s_axis_tdata[115:76];
          flg_d   = s_axis_tdata[127:116];
          lvl_d   = 2'd0;
          tbl_d   = '0;
          idx_d   = '0;
          res_status_d = STATUS_OK;
          res_phys_d   = '0;
          res_hit_d    = 1'b0;
          state_d = (s_axis_tuser == OP_MAP) ? ST_WALK_RD : ST_TLB_RD;
        end
      end
      ST_TLB_RD: begin
        if (idx_q >= tlb_fill) begin
          if (op_q == OP_MAP) begin
            state_d = ST_DONE;
          end else begin
            miss_cnt_d = miss_cnt_q + 32'd1;
            lvl_d   = 2'd0;
            tbl_d   = '0;
            state_d = ST_WALK_RD;
          end
        end else begin
          tlb_op.lookup = 1'b1;
          state_d = ST_TLB_CMP;
        end
      end
      ST_TLB_CMP: begin
        if (tlb_match) begin
          if (op_q == OP_MAP) begin
            tlb_op.inval = 1'b1;
          end else begin
            res_phys_d = {tlb_frame, va_q[11:0]};
            res_hit_d  = 1'b1;
            hit_cnt_d  = hit_cnt_q + 32'd1;
          end
          state_d = ST_DONE;
        end else begin
          idx_d   = idx_q + CW'(1);
          state_d = ST_TLB_RD;
        end
      end
      ST_WALK_RD: begin
        state_d = ST_WALK_EV;
      end
      ST_WALK_EV: begin
        if (op_q == OP_TRANSLATE) begin
          if (!ent_present || (lvl_q != 2'd3 && !ent_kvalid)) begin
            res_status_d = STATUS_FAULT;
            fault_cnt_d  = fault_cnt_q + 32'd1;
            state_d      = ST_DONE;
          end else if (lvl_q == 2'd3) begin
            pf_d    = ent_k;
            state_d = ST_FILL;
          end else begin
            tbl_d   = ent_km1[TW-1:0];
            lvl_d   = lvl_q + 2'd1;
            state_d = ST_WALK_RD;
          end
        end else begin
          if (!ent_present) begin
            state_d = ST_CHECK;
          end else if (!ent_kvalid) begin
            res_status_d = STATUS_NOTBL;
            state_d      = ST_DONE;
          end else begin
            tbl_d   = ent_km1[TW-1:0];
            lvl_d   = lvl_q + 2'd1;
            state_d = (lvl_q == 2'd2) ? ST_CHECK : ST_WALK_RD;
          end
        end
      end
      ST_CHECK: begin
        if (need_sum > (AW+1)'(PT_POOL_SIZE)) begin
          res_status_d = STATUS_NOTBL;
          state_d      = ST_DONE;
        end else begin
          state_d = (lvl_q == 2'd3) ? ST_LEAF : ST_ALLOC;
        end
      end
      ST_ALLOC: begin
        // Fresh tables read as zero: the clearing pass left them so.
        mem_we    = 1'b1;
        mem_wdata = {12'b0, new_k, flg_q | PRESENT_FLAG};
        tbl_d     = alloc_q[TW-1:0];
        alloc_d   = alloc_q + AW'(1);
        lvl_d     = lvl_q + 2'd1;
        state_d   = (lvl_q == 2'd2) ? ST_LEAF : ST_ALLOC;
      end
      ST_LEAF: begin
        mem_we    = 1'b1;
        mem_wdata = {12'b0, frame_q, flg_q | PRESENT_FLAG};
        idx_d     = '0;
        state_d   = ST_TLB_RD;
      end
      ST_FILL: begin
        tlb_op.fill = 1'b1;
        res_phys_d  = {pf_q, va_q[11:0]};
        state_d     = ST_DONE;
      end
      ST_DONE: begin
        // Hold until the output register is free.
        if (!mvalid_q || m_axis_tready) begin
          mvalid_d = 1'b1;
          mdata_d  = {3'b0, alloc_ext[5:0], fault_cnt_q, miss_cnt_q, hit_cnt_q,
                      res_hit_q, res_phys_q, res_status_q};
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      alloc_q     <= AW'(1);
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      fault_cnt_q <= '0;
      mvalid_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      alloc_q     <= alloc_d;
      hit_cnt_q   <= hit_cnt_d;
      miss_cnt_q  <= miss_cnt_d;
      fault_cnt_q <= fault_cnt_d;
      mvalid_q    <= mvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;  va_q <= va_d;  frame_q <= frame_d;  flg_q <= flg_d;
    lvl_q <= lvl_d;  tbl_q <= tbl_d;  idx_q <= idx_d;  pf_q <= pf_d;
    res_status_q <= res_status_d;  res_phys_q <= res_phys_d;  res_hit_q <= res_hit_d;
    mdata_q <= mdata_d;
  end

  mmu4_ram #(.WIDTH(ENTRY_W), .DEPTH(MD), .AW(MAW)) u_tables (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  mmu4_tlb #(.ENTRIES(TLB_ENTRIES), .IW(IW), .CW(CW)) u_tlb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .op_i    (tlb_op),
    .idx_i   (idx_q[IW-1:0]),
    .tag_i   (va_q[63:12]),
    .frame_i (pf_q),
    .match_o (tlb_match),
    .frame_o (tlb_frame),
    .fill_o  (tlb_fill)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = mdata_q;

  `MMU_ASSERT_NOW(a_alloc_bound, 1'b1, alloc_q <= AW'(PT_POOL_SIZE) && alloc_q != '0,
    "table allocation count out of range")
  `MMU_ASSERT_NEXT(a_accept_busy, s_axis_tvalid && s_axis_tready, state_q != ST_IDLE,
    "sequencer did not leave idle after an accepted item")
  `MMU_ASSERT_NOW(a_status_code, mvalid_q, mdata_q[1:0] != 2'd3,
    "result carries an undefined status code")
endmodule

### tb/four_level_mmu_with_tlb_core_test.sv
// Self-checking testbench for four_level_mmu_with_tlb_core: map and translate items are
// driven on the input stream, a behavioral page-walk and TLB model predicts each result.
// Depends on mmu4_pkg and the four_level_mmu_with_tlb_core RTL.
`timescale 1ns / 1ps
module four_level_mmu_with_tlb_core_test;
  import mmu4_pkg::*;

  localparam int NUM_TABLES = 32;
  localparam int NUM_TLB    = 64;
  localparam logic [63:0] FRAME_BITS = 64'h000F_FFFF_FFFF_F000;

  // Highest field first, so status lands in the lowest bits as on m_axis_tdata
  typedef struct packed {
    logic [5:0]  tables;
    logic [31:0] faults;
    logic [31:0] misses;
    logic [31:0] hits;
    logic        hit;
    logic [51:0] phys;
    logic [1:0]  status;
  } mmu_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata;
  logic              s_axis_tuser;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [OUT_W-1:0]  m_axis_tdata;

  four_level_mmu_with_tlb_core #(
    .PT_POOL_SIZE(NUM_TABLES),
    .TLB_ENTRIES(NUM_TLB)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Model state of the page-table pool and the TLB
  logic [63:0] page_mem [int];
  int unsigned tables_used;
  logic [51:0] tlb_tags   [NUM_TLB];
  logic [39:0] tlb_frames [NUM_TLB];
  logic        tlb_live   [NUM_TLB];
  int unsigned tlb_count;
  logic [31:0] hit_cnt, miss_cnt, fault_cnt;

  mmu_result_t pending_results[$];
  int          error_count;
  int          items_sent, maps_sent;
  int          tx_idle_pct, rx_idle_pct;
  logic [26:0] region_base [4];

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [63:0] mem_read(int unsigned tbl, logic [8:0] idx);
    int addr;
    addr = tbl * 512 + idx;
    return page_mem.exists(addr) ? page_mem[addr] : 64'd0;
  endfunction

  function automatic logic [8:0] walk_index(logic [63:0] va, int lvl);
    return 9'((va >> (39 - 9 * lvl)) & 64'h1FF);
  endfunction

  // Table named by an entry, or -1 when it points at no allocated table
  function automatic int pointed_table(logic [63:0] e);
    longint unsigned k;
    k = e[51:12];
    if (k >= 1 && k <= tables_used && k <= NUM_TABLES) return int'(k - 1);
    return -1;
  endfunction

  function automatic logic [1:0] apply_map(logic [63:0] va, logic [51:0] frame,
                                           logic [11:0] flg);
    int unsigned t;
    int          lvl, k, n;
    logic [63:0] e;
    t = 0;
    for (lvl = 0; lvl < 3; lvl++) begin
      e = mem_read(t, walk_index(va, lvl));
      if (!e[0]) break;
      k = pointed_table(e);
      if (k < 0) return STATUS_NOTBL;
      t = k;
    end
    if (tables_used + (3 - lvl) > NUM_TABLES) return STATUS_NOTBL;
    for (; lvl < 3; lvl++) begin
      n = tables_used;
      tables_used++;
      page_mem[t * 512 + walk_index(va, lvl)] =
        ((64'(n + 1) << 12) & FRAME_BITS) | 64'(flg) | 64'd1;
      t = n;
    end
    page_mem[t * 512 + walk_index(va, 3)] = (64'(frame) & FRAME_BITS) | 64'(flg) | 64'd1;
    for (int i = 0; i < tlb_count; i++) begin
      if (tlb_live[i] && tlb_tags[i] == va[63:12]) begin
        tlb_live[i] = 1'b0;
        break;
      end
    end
    return STATUS_OK;
  endfunction

  function automatic mmu_result_t predict_mmu(logic op, logic [63:0] va,
                                              logic [51:0] frame, logic [11:0] flg);
    mmu_result_t r;
    logic        found;
    int unsigned t, slot;
    int          k;
    logic [63:0] e, pf;
    r = '0;
    if (op == OP_MAP) begin
      r.status = apply_map(va, frame, flg);
    end else begin
      found = 1'b0;
      for (int i = 0; i < tlb_count; i++) begin
        if (tlb_live[i] && tlb_tags[i] == va[63:12]) begin
          r.phys = {tlb_frames[i], va[11:0]};
          r.hit  = 1'b1;
          hit_cnt++;
          found = 1'b1;
          break;
        end
      end
      if (!found) begin
        miss_cnt++;
        t  = 0;
        pf = '0;
        for (int lvl = 0; lvl < 4; lvl++) begin
          e = mem_read(t, walk_index(va, lvl));
          if (!e[0]) begin
            r.status = STATUS_FAULT;
            break;
          end
          if (lvl < 3) begin
            k = pointed_table(e);
            if (k < 0) begin
              r.status = STATUS_FAULT;
              break;
            end
            t = k;
          end else begin
            pf = e & FRAME_BITS;
          end
        end
        if (r.status == STATUS_FAULT) begin
          fault_cnt++;
        end else begin
          // evict slot 0 once the TLB is full
          if (tlb_count < NUM_TLB) begin
            slot = tlb_count;
            tlb_count++;
          end else begin
            slot = 0;
          end
          tlb_tags[slot]   = va[63:12];
          tlb_frames[slot] = pf[51:12];
          tlb_live[slot]   = 1'b1;
          r.phys = pf[51:0] | 52'(va[11:0]);
        end
      end
    end
    r.hits   = hit_cnt;
    r.misses = miss_cnt;
    r.faults = fault_cnt;
    r.tables = 6'(tables_used);
    return r;
  endfunction

  // Drive one item; returns on the falling edge after it was accepted
  task automatic send_request(logic op, logic [63:0] va, logic [51:0] frame,
                              logic [11:0] flg);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {flg, frame, va};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(predict_mmu(op, va, frame, flg));
    items_sent++;
    if (op == OP_MAP) maps_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_for_results();
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // Result consumer: random ready at the falling edge, check at the rising edge
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic void check_field(string name, logic [63:0] exp, logic [63:0] act);
    if (exp !== act) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    mmu_result_t want, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[156:0];
      if (pending_results.size() == 0) begin
        $error("result with nothing outstanding: 0x%0h", m_axis_tdata);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, got.status);
        check_field("paddr", want.phys, got.phys);
        check_field("tlb_hit", want.hit, got.hit);
        check_field("hit_total", want.hits, got.hits);
        check_field("miss_total", want.misses, got.misses);
        check_field("fault_total", want.faults, got.faults);
        check_field("tables_in_use", want.tables, got.tables);
      end
    end
  end

  task automatic test_basic_map_translate();
    send_request(OP_TRANSLATE, 64'h0, '0, '0);                 // fault on empty tables
    send_request(OP_MAP, 64'h0, {52{1'b1}}, 12'hFFF);
    send_request(OP_TRANSLATE, 64'h123, '0, '0);               // miss, walk succeeds
    send_request(OP_TRANSLATE, 64'hABC, '0, '0);               // hit
    send_request(OP_TRANSLATE, 64'hFFFF_0000_0000_0ABC, '0, '0); // same walk, new tag
  endtask

  task automatic test_address_extremes();
    send_request(OP_MAP, {64{1'b1}}, '0, '0);
    send_request(OP_TRANSLATE, {64{1'b1}}, '0, '0);
    send_request(OP_TRANSLATE, {64{1'b1}}, '0, '0);
    send_request(OP_TRANSLATE, 64'h0000_FFFF_FFFF_F000, '0, '0);
  endtask

  task automatic test_remap_invalidates();
    send_request(OP_MAP, 64'h0, 52'h5_A5A5_A5A5_A000, 12'h0F0);
    send_request(OP_TRANSLATE, 64'h7, '0, '0);                 // must miss and see new frame
    send_request(OP_TRANSLATE, 64'hFFFF_0000_0000_0007, '0, '0); // stale second entry hits
  endtask

  task automatic test_random_traffic(int tx_pct, int rx_pct, int count);
    int          r;
    logic        op;
    logic [63:0] va;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int n = 0; n < count; n++) begin
      r  = $urandom_range(99);
      va = {$urandom, $urandom};
      if (r < 2) begin
        op = OP_MAP;
      end else if (r < 8) begin
        op = OP_TRANSLATE;
      end else begin
        op = ($urandom_range(99) < 30) ? OP_MAP : OP_TRANSLATE;
        va[47:21] = region_base[$urandom_range(3)];
        va[20:12] = 9'($urandom_range(79));
        if ($urandom_range(1)) va[63:48] = '0;
      end
      send_request(op, va, 52'({$urandom, $urandom}), 12'($urandom));
      if (n == count / 2) wait_for_results();   // hold until all results are back
    end
  endtask

  task automatic test_pool_exhaustion();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (int i = 0; i < 12; i++)
      send_request(OP_MAP, 64'(100 + i) << 39, 52'(i) << 12, 12'h004);
    send_request(OP_TRANSLATE, 64'(100) << 39, '0, '0);
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = 1'b0;
    s_axis_tdata  = '0;
    error_count   = 0;
    items_sent    = 0;
    maps_sent     = 0;
    tx_idle_pct   = 0;
    rx_idle_pct   = 0;
    page_mem.delete();
    tables_used = 1;
    tlb_count   = 0;
    hit_cnt     = '0;
    miss_cnt    = '0;
    fault_cnt   = '0;
    foreach (tlb_live[i]) tlb_live[i] = 1'b0;
    foreach (region_base[i]) region_base[i] = 27'($urandom);
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_basic_map_translate();
    test_address_extremes();
    test_remap_invalidates();
    test_random_traffic(36, 87, 180);
    test_random_traffic(87, 36, 180);
    test_random_traffic(0, 0, 190);
    test_pool_exhaustion();

    wait_for_results();
    repeat (200) @(negedge clk_i);
    $display("Covered %0d items (%0d maps): %0d TLB hits, %0d misses, %0d faults,",
             items_sent, maps_sent, hit_cnt, miss_cnt, fault_cnt);
    $display("%0d page tables in use at the end of the run.", tables_used);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
